/* rtl/tpm_pkg.sv */
// Package for the two-slave bus poll master: beat and config structs,
// command codes and frame byte constants. No dependencies.
`default_nettype none

package tpm_pkg;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_POLL    = 2'd1,
      CMD_BUS_RX  = 2'd2,
      CMD_HOST_RX = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_FIRST_WAIT  = 2'd0,
      CSR_SECOND_WAIT = 2'd1,
      CSR_IDLE_TICKS  = 2'd2,
      CSR_LEVEL_MAX   = 2'd3
   } csr_index_type;

   localparam logic [7:0] HEAD_BYTE   = 8'hAA;
   localparam logic [7:0] ID_FIRST    = 8'h01;
   localparam logic [7:0] ID_SECOND   = 8'h02;
   localparam logic [7:0] POLL_FIRST  = 8'hE1;
   localparam logic [7:0] POLL_SECOND = 8'hE2;
   localparam logic [7:0] DL_FIRST    = 8'hD1;
   localparam logic [7:0] DL_SECOND   = 8'hD2;

   localparam logic [7:0] FIRST_WAIT_RST  = 8'd3;
   localparam logic [7:0] SECOND_WAIT_RST = 8'd4;
   localparam logic [7:0] IDLE_TICKS_RST  = 8'd2;
   localparam logic [7:0] LEVEL_MAX_RST   = 8'd3;

   typedef struct packed {
      logic [7:0] first_wait_ticks;
      logic [7:0] second_wait_ticks;
      logic [7:0] idle_ticks_before_downlink;
      logic [7:0] level_max;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] frame_head;
      logic [7:0] frame_code;
      logic [7:0] frame_value;
      logic       bus_tx_free;
      logic       host_tx_free;
   } req_type;

   typedef struct packed {
      logic       host_send;
      logic [7:0] host_code;
      logic [7:0] host_value;
      logic       bus_send;
      logic [7:0] bus_code;
      logic [7:0] bus_value;
      logic       activity_led;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/two_slave_bus_poll_master.sv */
// Top level of the two-slave bus poll master: input register, step core,
// result register and config registers. Depends on tpm_pkg, tpm_csr, tpm_core.
//
//   channel | dir | handshake          | beat
//   req_    | in  | req_valid/stall    | cmd, frame head/code/value, tx free flags
//   rsp_    | out | rsp_valid/stall    | host and bus frames, activity led
//   csr_    | in  | csr_valid/ready    | register index, 8-bit data
//
// One beat per cycle sustained while rsp_stall is low; a beat passes the input
// register, then the step logic into the result register.
// Synchronous active-high reset clears the valid flags of both stages and all
// core state, and loads the config defaults. csr_ready is always high.
// A stalled result holds; the input register then fills and req_stall rises.
`default_nettype none

module two_slave_bus_poll_master
   import tpm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_frame_head,
   input  wire logic [7:0] req_frame_code,
   input  wire logic [7:0] req_frame_value,
   input  wire logic       req_bus_tx_free,
   input  wire logic       req_host_tx_free,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_host_send,
   output logic [7:0]      rsp_host_code,
   output logic [7:0]      rsp_host_value,
   output logic            rsp_bus_send,
   output logic [7:0]      rsp_bus_code,
   output logic [7:0]      rsp_bus_value,
   output logic            rsp_activity_led,

   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);

   logic    in_valid_ff,  in_valid_in;
   req_type in_item_ff,   in_item_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff,  out_item_in;

   logic    out_free;
   logic    advance;
   logic    accept;
   cfg_type cfg;
   rsp_type step_result;

   assign csr_ready = 1'b1;

   tpm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   tpm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (step_result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !advance);
      in_item_in   = in_item_ff;
      if (accept) begin
         in_item_in.cmd          = req_cmd;
         in_item_in.frame_head   = req_frame_head;
         in_item_in.frame_code   = req_frame_code;
         in_item_in.frame_value  = req_frame_value;
         in_item_in.bus_tx_free  = req_bus_tx_free;
         in_item_in.host_tx_free = req_host_tx_free;
      end
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      out_item_in  = advance ? step_result : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_host_send    = out_item_ff.host_send;
   assign rsp_host_code    = out_item_ff.host_code;
   assign rsp_host_value   = out_item_ff.host_value;
   assign rsp_bus_send     = out_item_ff.bus_send;
   assign rsp_bus_code     = out_item_ff.bus_code;
   assign rsp_bus_value    = out_item_ff.bus_value;
   assign rsp_activity_led = out_item_ff.activity_led;

   a_bus_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_send |->
         (rsp_bus_code == POLL_FIRST || rsp_bus_code == POLL_SECOND ||
          rsp_bus_code == DL_FIRST || rsp_bus_code == DL_SECOND))
      else $error("bus frame with illegal code");

   a_host_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_host_send |-> rsp_host_code == 8'd0 && rsp_host_value == 8'd0)
      else $error("host bytes set without a host frame");

   a_led_on_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_host_send |-> rsp_activity_led)
      else $error("host frame forwarded with led off");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("req_stall without a full pipeline");

endmodule

`default_nettype wire

/* rtl/tpm_csr.sv */
// Configuration registers of the poll master, written over the csr beat channel.
// Depends on tpm_pkg.
`default_nettype none

module tpm_csr
   import tpm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_en,
   input  wire logic [1:0] wr_index,
   input  wire logic [7:0] wr_data,
   output cfg_type         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_FIRST_WAIT:  cfg_in.first_wait_ticks = wr_data;
            CSR_SECOND_WAIT: cfg_in.second_wait_ticks = wr_data;
            CSR_IDLE_TICKS:  cfg_in.idle_ticks_before_downlink = wr_data;
            CSR_LEVEL_MAX:   cfg_in.level_max = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_wait_ticks           <= FIRST_WAIT_RST;
         cfg_ff.second_wait_ticks          <= SECOND_WAIT_RST;
         cfg_ff.idle_ticks_before_downlink <= IDLE_TICKS_RST;
         cfg_ff.level_max                  <= LEVEL_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/tpm_core.sv */
// Poll/downlink state and the single-pass step logic of the poll master.
// Depends on tpm_pkg.
`default_nettype none

module tpm_core
   import tpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire cfg_type cfg,
   input  wire req_type item,
   output rsp_type      result
);

   logic       awaiting_first_ff,  awaiting_first_in;
   logic       awaiting_second_ff, awaiting_second_in;
   logic [7:0] tick_count_ff,      tick_count_in;
   logic       pending_first_ff,   pending_first_in;
   logic       pending_second_ff,  pending_second_in;
   logic [7:0] level_first_ff,     level_first_in;
   logic [7:0] level_second_ff,    level_second_in;
   logic       led_lit_ff,         led_lit_in;

   logic [7:0] tick_next;
   logic [7:0] level_clamped;
   logic       head_ok;
   rsp_type    res;

   assign tick_next     = tick_count_ff + 8'd1;
   assign level_clamped = (item.frame_value > cfg.level_max) ? cfg.level_max : item.frame_value;
   assign head_ok       = (item.frame_head == HEAD_BYTE);

   always_comb begin
      awaiting_first_in  = awaiting_first_ff;
      awaiting_second_in = awaiting_second_ff;
      tick_count_in      = tick_count_ff;
      pending_first_in   = pending_first_ff;
      pending_second_in  = pending_second_ff;
      level_first_in     = level_first_ff;
      level_second_in    = level_second_ff;
      led_lit_in         = led_lit_ff;
      res                = '0;

      case (cmd_type'(item.cmd))
         CMD_TICK: begin
            tick_count_in = tick_next;
            if (awaiting_first_ff && tick_next >= cfg.first_wait_ticks) begin
               res.bus_send       = item.bus_tx_free;
               res.bus_code       = item.bus_tx_free ? POLL_SECOND : 8'd0;
               awaiting_first_in  = 1'b0;
               awaiting_second_in = 1'b1;
               tick_count_in      = 8'd0;
            end else if (awaiting_second_ff && tick_next >= cfg.second_wait_ticks) begin
               awaiting_second_in = 1'b0;
               tick_count_in      = 8'd0;
            end else if (!awaiting_first_ff && !awaiting_second_ff &&
                         tick_next >= cfg.idle_ticks_before_downlink &&
                         item.bus_tx_free) begin
               if (pending_first_ff) begin
                  res.bus_send     = 1'b1;
                  res.bus_code     = DL_FIRST;
                  res.bus_value    = level_first_ff;
                  pending_first_in = 1'b0;
               end else if (pending_second_ff) begin
                  res.bus_send      = 1'b1;
                  res.bus_code      = DL_SECOND;
                  res.bus_value     = level_second_ff;
                  pending_second_in = 1'b0;
               end
            end
         end
         CMD_POLL: begin
            res.bus_send       = item.bus_tx_free;
            res.bus_code       = item.bus_tx_free ? POLL_FIRST : 8'd0;
            awaiting_first_in  = 1'b1;
            awaiting_second_in = 1'b0;
            tick_count_in      = 8'd0;
         end
         CMD_BUS_RX: begin
            if (head_ok) begin
               if (item.frame_code == ID_FIRST && awaiting_first_ff) begin
                  res.bus_send       = item.bus_tx_free;
                  res.bus_code       = item.bus_tx_free ? POLL_SECOND : 8'd0;
                  awaiting_first_in  = 1'b0;
                  awaiting_second_in = 1'b1;
                  tick_count_in      = 8'd0;
                  if (item.host_tx_free) begin
                     res.host_send  = 1'b1;
                     res.host_code  = item.frame_code;
                     res.host_value = item.frame_value;
                     led_lit_in     = 1'b1;
                  end
               end else if (item.frame_code == ID_SECOND && awaiting_second_ff) begin
                  awaiting_second_in = 1'b0;
                  if (item.host_tx_free) begin
                     res.host_send  = 1'b1;
                     res.host_code  = item.frame_code;
                     res.host_value = item.frame_value;
                     led_lit_in     = 1'b1;
                  end
               end
            end
         end
         CMD_HOST_RX: begin
            if (head_ok) begin
               if (item.frame_code == DL_FIRST) begin
                  level_first_in   = level_clamped;
                  pending_first_in = 1'b1;
               end else if (item.frame_code == DL_SECOND) begin
                  level_second_in   = level_clamped;
                  pending_second_in = 1'b1;
               end
            end
         end
         default: res = '0;
      endcase

      res.activity_led = led_lit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_first_ff  <= 1'b0;
         awaiting_second_ff <= 1'b0;
         tick_count_ff      <= 8'd0;
         pending_first_ff   <= 1'b0;
         pending_second_ff  <= 1'b0;
         level_first_ff     <= 8'd0;
         level_second_ff    <= 8'd0;
         led_lit_ff         <= 1'b0;
      end else if (fire) begin
         awaiting_first_ff  <= awaiting_first_in;
         awaiting_second_ff <= awaiting_second_in;
         tick_count_ff      <= tick_count_in;
         pending_first_ff   <= pending_first_in;
         pending_second_ff  <= pending_second_in;
         level_first_ff     <= level_first_in;
         level_second_ff    <= level_second_in;
         led_lit_ff         <= led_lit_in;
      end
   end

   assign result = res;

endmodule

`default_nettype wire
